FILE: sv/khm_pkg.sv
// Shared types and constants for the key transition heatmap.
`default_nettype none

package khm_pkg;

    localparam int KEY_ROWS_DEF = 4;
    localparam int KEY_COLS_DEF = 16;
    localparam int COUNT_W      = 32;
    localparam int LEVEL_W      = 8;
    localparam int LEVEL_MAX    = 255;

    typedef struct packed {
        logic [1:0] key_row;
        logic [3:0] key_col;
    } khm_in_t;

    typedef struct packed {
        logic [1:0]         led_row;
        logic [3:0]         led_col;
        logic [LEVEL_W-1:0] intensity;
        logic               last_led;
    } khm_out_t;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] divisor;
    } khm_div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } khm_div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/key_transition_heatmap_top.sv
// Top level of the key transition heatmap: count store, sequencer and result register.
//
//   channel  ports                          moves
//   -------  -----------------------------  -------------------------------
//   input    s_valid, s_ready, s_data       one key-press request
//   result   m_valid, m_ready, m_data       one LED intensity per key
//
// After reset a clearing pass writes zero to every count, one entry a cycle,
// over all KEY_ROWS*KEY_COLS squared entries (4096 at the defaults); no
// request is taken meanwhile. An event then runs from its acceptance back
// to idle as one count read per key for the maximum, then per key a read,
// a start, eight serial division steps, registering of the quotient and
// the emit. Each result sits in an output register, so a stalled m_ready
// only holds the sequencer at its next result.
`default_nettype none

module key_transition_heatmap_top #(
    parameter int KEY_ROWS = khm_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS = khm_pkg::KEY_COLS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire khm_pkg::khm_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output khm_pkg::khm_out_t      m_data
);
    import khm_pkg::*;

    localparam int NUM_KEYS = KEY_ROWS * KEY_COLS;
    localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int RW       = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int CW       = (KEY_COLS > 1) ? $clog2(KEY_COLS) : 1;
    localparam int AW       = 2 * KW;
    localparam int DEPTH    = NUM_KEYS * NUM_KEYS;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_INC_RD    = 10'b0000000100,
        S_INC_WR    = 10'b0000001000,
        S_SCAN      = 10'b0000010000,
        S_SCAN_END  = 10'b0000100000,
        S_DIV_RD    = 10'b0001000000,
        S_DIV_START = 10'b0010000000,
        S_DIV_RUN   = 10'b0100000000,
        S_EMIT      = 10'b1000000000
    } khm_state_t;

    khm_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr, wr_addr, clr_reg;
    logic               rd_en, wr_en;
    logic [COUNT_W-1:0] wr_data;
    logic [KW-1:0]      prev_reg, to_reg, k_reg;
    logic [RW-1:0]      k_row_reg;
    logic [CW-1:0]      k_col_reg;
    logic [COUNT_W-1:0] max_reg;
    logic               scan_vld_reg;
    logic [KW-1:0]      in_idx;
    logic               in_ok;
    logic               accept;
    logic               k_last;
    logic               emit_go;
    logic [LEVEL_W-1:0] level_reg;
    logic               m_valid_reg;
    khm_out_t           m_data_reg;
    khm_div_req_t       div_req;
    khm_div_rsp_t       div_rsp;

    assign in_ok  = (32'(s_data.key_row) < KEY_ROWS) && (32'(s_data.key_col) < KEY_COLS);
    assign in_idx = KW'(32'(s_data.key_row) * KEY_COLS + 32'(s_data.key_col));
    assign accept = s_valid && s_ready;
    assign k_last = (k_reg == KW'(NUM_KEYS - 1));
    assign emit_go = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    // Count store: one write port, one registered read port.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(32'(to_reg) * NUM_KEYS + 32'(k_reg));
        wr_en   = 1'b0;
        wr_addr = AW'(32'(prev_reg) * NUM_KEYS + 32'(to_reg));
        wr_data = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            S_INC_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(32'(prev_reg) * NUM_KEYS + 32'(to_reg));
            end
            S_INC_WR: begin
                wr_en = 1'b1;
            end
            S_SCAN, S_DIV_RD: begin
                rd_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept && in_ok) state_next = S_INC_RD;
            end
            S_INC_RD:    state_next = S_INC_WR;
            S_INC_WR:    state_next = S_SCAN;
            S_SCAN: begin
                if (k_last) state_next = S_SCAN_END;
            end
            S_SCAN_END:  state_next = S_DIV_RD;
            S_DIV_RD:    state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_RUN;
            S_DIV_RUN: begin
                if (div_rsp.done) state_next = S_EMIT;
            end
            S_EMIT: begin
                if (emit_go) state_next = k_last ? S_IDLE : S_DIV_RD;
            end
            default:     state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            prev_reg     <= '0;
            scan_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_vld_reg <= (state_reg == S_SCAN);
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_INC_WR) begin
                prev_reg <= to_reg;
            end
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Key walk, running maximum and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            to_reg <= in_idx;
        end
        if (state_reg == S_INC_WR || state_reg == S_SCAN_END) begin
            k_reg     <= '0;
            k_row_reg <= '0;
            k_col_reg <= '0;
        end else if (state_reg == S_SCAN || emit_go) begin
            k_reg <= k_reg + 1'b1;
            if (k_col_reg == CW'(KEY_COLS - 1)) begin
                k_col_reg <= '0;
                k_row_reg <= k_row_reg + 1'b1;
            end else begin
                k_col_reg <= k_col_reg + 1'b1;
            end
        end
        if (state_reg == S_INC_WR) begin
            max_reg <= '0;
        end else if (scan_vld_reg && rd_data_reg > max_reg) begin
            max_reg <= rd_data_reg;
        end
        if (div_rsp.done) begin
            level_reg <= (max_reg == '0) ? '0 : div_rsp.quotient;
        end
        if (emit_go) begin
            m_data_reg.led_row   <= 2'(k_row_reg);
            m_data_reg.led_col   <= 4'(k_col_reg);
            m_data_reg.intensity <= level_reg;
            m_data_reg.last_led  <= k_last;
        end
    end

    assign div_req.start   = (state_reg == S_DIV_START);
    assign div_req.count   = rd_data_reg;
    assign div_req.divisor = max_reg;

    khm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sv/khm_div.sv
// Bit-serial divider producing floor(count * 255 / divisor), one quotient bit per cycle.
`default_nettype none

module khm_div (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire khm_pkg::khm_div_req_t req,
    output khm_pkg::khm_div_rsp_t      rsp
);
    import khm_pkg::*;

    localparam int NUM_W = COUNT_W + LEVEL_W;
    localparam int BIT_W = $clog2(LEVEL_W);

    logic [NUM_W-1:0]   num;
    logic [COUNT_W-1:0] rem_reg,  rem_next;
    logic [LEVEL_W-1:0] low_reg,  low_next;
    logic [LEVEL_W-1:0] quo_reg,  quo_next;
    logic [COUNT_W-1:0] dvs_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   trial;
    logic               take;

    // count * 255 as (count << 8) - count
    assign num = {req.count, LEVEL_W'(0)} - NUM_W'(req.count);

    // The quotient fits in eight bits because count never exceeds the divisor,
    // so the upper part of the numerator starts below the divisor.
    assign trial = {rem_reg, low_reg[LEVEL_W-1]};
    assign take  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next = take ? COUNT_W'(trial - {1'b0, dvs_reg}) : COUNT_W'(trial);
        low_next = {low_reg[LEVEL_W-2:0], 1'b0};
        quo_next = {quo_reg[LEVEL_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= num[NUM_W-1:LEVEL_W];
            low_reg <= num[LEVEL_W-1:0];
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (bit_reg == BIT_W'(LEVEL_W - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                bit_reg  <= '0;
            end else if (busy_reg) begin
                bit_reg <= bit_reg + 1'b1;
                if (bit_reg == BIT_W'(LEVEL_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire
